FILE: sv/blsm_pkg.sv
// ----------------------------------------------------------------------------
// blsm_pkg
// shared types and codes for the byte addressed load/store memory
// ----------------------------------------------------------------------------
package blsm_pkg;

   typedef logic [1:0]  opcode_type;
   typedef logic [1:0]  size_type;
   typedef logic [1:0]  status_type;
   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   // lane memory controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } lane_ctl_type;

   localparam opcode_type OP_LOAD_S = 2'd0;
   localparam opcode_type OP_LOAD_U = 2'd1;
   localparam opcode_type OP_STORE  = 2'd2;
   localparam opcode_type OP_UNUSED = 2'd3;

   localparam size_type SIZE_BYTE    = 2'd0;
   localparam size_type SIZE_HALF    = 2'd1;
   localparam size_type SIZE_WORD    = 2'd2;
   localparam size_type SIZE_ILLEGAL = 2'd3;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_BELOW   = 2'd1;
   localparam status_type STATUS_BEYOND  = 2'd2;
   localparam status_type STATUS_ILLEGAL = 2'd3;

   localparam word_type BASE_RESET     = 32'h8000_0000;
   localparam word_type SEXT_BYTE_MASK = 32'hFFFF_FF00;
   localparam word_type SEXT_HALF_MASK = 32'hFFFF_0000;

   localparam int LANES = 4;

endpackage

FILE: sv/blsm_channels.sv
// ----------------------------------------------------------------------------
// blsm channels
// request and response handshake channels
// ----------------------------------------------------------------------------
interface blsm_req_if;
   logic                   valid;
   logic                   ready;
   blsm_pkg::opcode_type   opcode;
   blsm_pkg::size_type     size_code;
   blsm_pkg::word_type     address;
   blsm_pkg::word_type     store_data;

   modport source (output valid, opcode, size_code, address, store_data, input ready);
   modport sink   (input valid, opcode, size_code, address, store_data, output ready);
endinterface

interface blsm_rsp_if;
   logic                   valid;
   logic                   ready;
   blsm_pkg::word_type     load_data;
   blsm_pkg::status_type   status;

   modport source (output valid, load_data, status, input ready);
   modport sink   (input valid, load_data, status, output ready);
endinterface

FILE: sv/blsm_lane_ram.sv
// ----------------------------------------------------------------------------
// blsm_lane_ram
// one byte lane of the data memory, single port, registered read
// ----------------------------------------------------------------------------
module blsm_lane_ram #(
   parameter int ROWS  = 16384,
   parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                   clock,
   input  blsm_pkg::lane_ctl_type ctl,
   input  logic [ROW_W-1:0]       row,
   input  blsm_pkg::byte_type     wr_byte,
   output blsm_pkg::byte_type     rd_byte
);

   blsm_pkg::byte_type mem_ff [ROWS];
   blsm_pkg::byte_type rd_byte_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[row] <= wr_byte;
      end
      if (ctl.rd_en) begin
         rd_byte_ff <= mem_ff[row];
      end
   end

   assign rd_byte = rd_byte_ff;

endmodule

FILE: sv/byte_addressed_load_store_memory.sv
// ----------------------------------------------------------------------------
// byte_addressed_load_store_memory
// byte addressed data memory with signed/unsigned loads and narrow stores
// ----------------------------------------------------------------------------
// an accepted item passes the check, lane access and read-assemble steps
//   through the four single-ported byte lanes; the next item is taken only in
//   idle, after the read step registers a result once the output is free
// reset: clears control state and base_address to 0x80000000; memory
//   contents stay undefined until written, no clearing pass
module byte_addressed_load_store_memory #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   blsm_req_if.sink            req_ch,
   blsm_rsp_if.source          rsp_ch,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int ROWS  = (MEM_BYTES + 3) / 4;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int OFF_W = ROW_W + 2;
   localparam blsm_pkg::word_type MEM_LIMIT = 32'(MEM_BYTES);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CHECK  = 2'd1;
   localparam logic [1:0] S_ACCESS = 2'd2;
   localparam logic [1:0] S_READ   = 2'd3;

   logic [1:0]             state_ff, state_in;
   blsm_pkg::opcode_type   op_ff;
   blsm_pkg::size_type     size_ff;
   blsm_pkg::word_type     addr_ff;
   blsm_pkg::word_type     wdata_ff;
   blsm_pkg::word_type     off_ff, off_in;
   blsm_pkg::status_type   status_ff, status_in;
   blsm_pkg::word_type     base_ff;
   logic                   rsp_valid_ff;
   blsm_pkg::word_type     load_out_ff, load_in;
   blsm_pkg::status_type   status_out_ff;

   logic                   req_accept;
   logic                   csr_write;
   logic                   out_free;
   logic                   illegal;
   logic [32:0]            diff;
   logic [2:0]             nbytes;
   logic                   beyond;
   logic                   go_ok;

   blsm_pkg::lane_ctl_type lane_ctl  [blsm_pkg::LANES];
   logic [ROW_W-1:0]       lane_row  [blsm_pkg::LANES];
   blsm_pkg::byte_type     lane_wr   [blsm_pkg::LANES];
   blsm_pkg::byte_type     lane_rd   [blsm_pkg::LANES];
   blsm_pkg::byte_type     gathered  [blsm_pkg::LANES];

   // handshakes
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready   = 1'b1;
   assign csr_prdata   = (csr_paddr[2] == 1'b0) ? base_ff : 32'd0;

   // check step
   always_comb begin
      illegal = (size_ff == blsm_pkg::SIZE_ILLEGAL) || (op_ff == blsm_pkg::OP_UNUSED) ||
                (op_ff == blsm_pkg::OP_LOAD_U && size_ff == blsm_pkg::SIZE_WORD);
      diff    = {1'b0, addr_ff} - {1'b0, base_ff};
      off_in  = diff[31:0];
      priority if (illegal) begin
         status_in = blsm_pkg::STATUS_ILLEGAL;
      end else if (diff[32]) begin
         status_in = blsm_pkg::STATUS_BELOW;
      end else begin
         status_in = blsm_pkg::STATUS_OK;
      end
   end

   // access step: range check and lane steering
   always_comb begin
      logic [1:0] sel;
      nbytes = 3'd1 << size_ff;
      beyond = off_ff > (MEM_LIMIT - 32'(nbytes));
      go_ok  = (state_ff == S_ACCESS) && (status_ff == blsm_pkg::STATUS_OK) && !beyond;
      for (int k = 0; k < blsm_pkg::LANES; k++) begin
         sel               = 2'(k) - off_ff[1:0];
         lane_row[k]       = off_ff[OFF_W-1:2] + ROW_W'(2'(k) < off_ff[1:0]);
         lane_wr[k]        = wdata_ff[{sel, 3'b000} +: 8];
         lane_ctl[k].wr_en = go_ok && ({1'b0, sel} < nbytes) && (op_ff == blsm_pkg::OP_STORE);
         lane_ctl[k].rd_en = go_ok && ({1'b0, sel} < nbytes) && (op_ff != blsm_pkg::OP_STORE);
      end
   end

   for (genvar k = 0; k < blsm_pkg::LANES; k++) begin : g_lane
      blsm_lane_ram #(
         .ROWS  (ROWS),
         .ROW_W (ROW_W)
      ) u_lane (
         .clock   (clock),
         .ctl     (lane_ctl[k]),
         .row     (lane_row[k]),
         .wr_byte (lane_wr[k]),
         .rd_byte (lane_rd[k])
      );
   end

   // read step: gather little-endian and extend
   always_comb begin
      for (int i = 0; i < blsm_pkg::LANES; i++) begin
         gathered[i] = lane_rd[2'(off_ff[1:0] + 2'(i))];
      end
      unique case (size_ff)
         blsm_pkg::SIZE_BYTE: begin
            load_in = {24'd0, gathered[0]};
            if (op_ff == blsm_pkg::OP_LOAD_S && gathered[0][7]) begin
               load_in = load_in | blsm_pkg::SEXT_BYTE_MASK;
            end
         end
         blsm_pkg::SIZE_HALF: begin
            load_in = {16'd0, gathered[1], gathered[0]};
            if (op_ff == blsm_pkg::OP_LOAD_S && gathered[1][7]) begin
               load_in = load_in | blsm_pkg::SEXT_HALF_MASK;
            end
         end
         blsm_pkg::SIZE_WORD: begin
            load_in = {gathered[3], gathered[2], gathered[1], gathered[0]};
         end
         default: begin
            load_in = 32'd0;
         end
      endcase
      if (status_ff != blsm_pkg::STATUS_OK || op_ff == blsm_pkg::OP_STORE) begin
         load_in = 32'd0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_accept) state_in = S_CHECK;
         S_CHECK:  state_in = S_ACCESS;
         S_ACCESS: state_in = S_READ;
         S_READ:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= blsm_pkg::BASE_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_write && csr_paddr[2] == 1'b0) begin
            base_ff <= csr_pwdata;
         end
         if (state_ff == S_READ && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_ch.opcode;
         size_ff  <= req_ch.size_code;
         addr_ff  <= req_ch.address;
         wdata_ff <= req_ch.store_data;
      end
      if (state_ff == S_CHECK) begin
         off_ff    <= off_in;
         status_ff <= status_in;
      end else if (state_ff == S_ACCESS && status_ff == blsm_pkg::STATUS_OK && beyond) begin
         status_ff <= blsm_pkg::STATUS_BEYOND;
      end
      if (state_ff == S_READ && out_free) begin
         load_out_ff   <= load_in;
         status_out_ff <= status_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.load_data = load_out_ff;
   assign rsp_ch.status    = status_out_ff;

   // lane writes only from a checked store
   a_write_only_store: assert property (@(posedge clock) disable iff (reset)
      (lane_ctl[0].wr_en || lane_ctl[1].wr_en || lane_ctl[2].wr_en || lane_ctl[3].wr_en)
      |-> (state_ff == S_ACCESS && op_ff == blsm_pkg::OP_STORE &&
           status_ff == blsm_pkg::STATUS_OK))
      else $error("lane write outside a valid store");

   // an accepted item goes straight to the check step
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_CHECK))
      else $error("accepted item did not enter check");

   // faults and stores return zero data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_out_ff != blsm_pkg::STATUS_OK) |-> (load_out_ff == 32'd0))
      else $error("faulting item returned data");

   // a finished result is never dropped by the next one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff)
      else $error("pending result lost");

endmodule
